// ===== design/rfp_pkg.sv =====
// Shared types and constants for the CRC-checked reply frame parser.
`default_nettype none

package rfp_pkg;

  // Frame characters and status codes.
  localparam logic [7:0] ChReply  = 8'h52;
  localparam logic [7:0] ChGet    = 8'h47;
  localparam logic [7:0] StAck    = 8'h06;
  localparam logic [7:0] StData   = 8'h81;
  localparam logic [7:0] StCount  = 8'h82;
  localparam logic [7:0] StCmd    = 8'h83;
  localparam logic [7:0] StPerm   = 8'h84;

  // Register reset values.
  localparam logic [15:0] PolyReset = 16'h1021;
  localparam logic [15:0] IdleReset = 16'd5000;

  // Fixed frame sizes.
  localparam logic [8:0] ShortFrameSize = 9'd5;
  localparam logic [8:0] GetFrameBase   = 9'd7;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_CRC_POLY   = 1'b0,
    CFG_IDLE_LIMIT = 1'b1
  } cfg_idx_e;

  // Reported outcome codes.
  typedef enum logic [2:0] {
    OUT_OK        = 3'd0,
    OUT_TIMEOUT   = 3'd1,
    OUT_CRC_BAD   = 3'd2,
    OUT_DATA_ERR  = 3'd3,
    OUT_COUNT_ERR = 3'd4,
    OUT_CMD_ERR   = 3'd5,
    OUT_PERM_ERR  = 3'd6,
    OUT_OTHER_NAK = 3'd7
  } outcome_e;

  // One input item.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] rx_byte;
    logic [7:0] expected_type;
  } rfp_item_t;

  // One result item.
  typedef struct packed {
    outcome_e    outcome;
    logic [7:0]  reply_type;
    logic        type_mismatch;
    logic [15:0] data_word;
    logic [7:0]  data_length;
    logic [8:0]  frame_bytes;
  } rfp_result_t;

endpackage

`default_nettype wire

// ===== design/rfp_in_stage.sv =====
// Input register stage holding one accepted item for the frame logic.
`default_nettype none

module rfp_in_stage
  import rfp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire rfp_item_t in_item_i,
  input  wire logic      take_i,
  output logic           item_valid_o,
  output rfp_item_t      item_o
);

  logic      valid_q;
  logic      valid_d;
  rfp_item_t item_q;
  logic      load;

  // The register can take a new item when empty or when its item moves on.
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== design/rfp_core.sv =====
// Frame state, CRC update, idle timeout and result generation.
`default_nettype none

module rfp_core
  import rfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        step_i,
  input  wire rfp_item_t   item_i,
  output logic             res_valid_o,
  output rfp_result_t      res_o
);

  // One byte of CRC-16, MSB first, with the programmed polynomial.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Checksum first, then the status byte.
  function automatic outcome_e judge(input logic [15:0] tail, input logic [15:0] crc,
                                     input logic [7:0] status);
    outcome_e o;
    if (tail[15:8] != crc[7:0] || tail[7:0] != crc[15:8]) begin
      o = OUT_CRC_BAD;
    end else begin
      unique case (status)
        StAck:   o = OUT_OK;
        StData:  o = OUT_DATA_ERR;
        StCount: o = OUT_COUNT_ERR;
        StCmd:   o = OUT_CMD_ERR;
        StPerm:  o = OUT_PERM_ERR;
        default: o = OUT_OTHER_NAK;
      endcase
    end
    return o;
  endfunction

  logic [15:0] poly_q, limit_q;
  logic        in_frame_q, in_frame_d;
  logic [8:0]  count_q, count_d;
  logic [8:0]  size_q, size_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  length_q, length_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] tail_q, tail_d;
  logic [15:0] data_q, data_d;
  logic [15:0] idle_q, idle_d;
  logic        mism_q, mism_d;

  // Values after the current byte, before any end-of-frame clear.
  logic [8:0]  count_n, size_n;
  logic [7:0]  type_n, status_n, length_n;
  logic [15:0] crc_n, tail_n, data_n;
  logic        mism_n;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q  <= PolyReset;
      limit_q <= IdleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_CRC_POLY:   poly_q  <= cfg_wdata_i;
        CFG_IDLE_LIMIT: limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Byte-in-frame update.
  always_comb begin
    count_n  = count_q + 9'd1;
    crc_n    = (count_n >= 9'd3) ? crc_byte(crc_q, tail_q[15:8], poly_q) : crc_q;
    tail_n   = {tail_q[7:0], item_i.rx_byte};
    size_n   = size_q;
    type_n   = type_q;
    status_n = status_q;
    length_n = length_q;
    data_n   = data_q;
    mism_n   = mism_q;
    if (count_n == 9'd2) begin
      type_n = item_i.rx_byte;
      mism_n = (item_i.rx_byte != item_i.expected_type);
      size_n = (item_i.rx_byte == ChGet) ? 9'd0 : ShortFrameSize;
    end else if (count_n == 9'd3) begin
      status_n = item_i.rx_byte;
    end else if (count_n == 9'd4 && type_q == ChGet) begin
      if (status_q == StAck) begin
        length_n = item_i.rx_byte;
        size_n   = GetFrameBase + {1'b0, item_i.rx_byte};
      end else begin
        size_n = ShortFrameSize;
      end
    end else if (count_n == 9'd6) begin
      data_n = {data_q[15:8], item_i.rx_byte};
    end else if (count_n == 9'd7) begin
      data_n = {item_i.rx_byte, data_q[7:0]};
    end
  end

  // Next state and result for the item being processed.
  always_comb begin
    in_frame_d  = in_frame_q;
    count_d     = count_q;
    size_d      = size_q;
    type_d      = type_q;
    status_d    = status_q;
    length_d    = length_q;
    crc_d       = crc_q;
    tail_d      = tail_q;
    data_d      = data_q;
    idle_d      = idle_q;
    mism_d      = mism_q;
    res_valid_o = 1'b0;
    res_o.outcome       = OUT_TIMEOUT;
    res_o.reply_type    = type_q;
    res_o.type_mismatch = mism_q;
    res_o.data_word     = data_q;
    res_o.data_length   = length_q;
    res_o.frame_bytes   = count_q;
    if (step_i) begin
      if (!item_i.has_byte) begin
        // Idle tick: time out or count.
        if (idle_q >= limit_q) begin
          res_valid_o = 1'b1;
          in_frame_d  = 1'b0;
          count_d     = '0;
          size_d      = '0;
          type_d      = '0;
          status_d    = '0;
          length_d    = '0;
          crc_d       = '0;
          tail_d      = '0;
          data_d      = '0;
          mism_d      = 1'b0;
          idle_d      = '0;
        end else begin
          idle_d = idle_q + 16'd1;
        end
      end else if (!in_frame_q) begin
        // Hunting: only the reply character opens a frame.
        if (item_i.rx_byte == ChReply) begin
          in_frame_d = 1'b1;
          count_d    = 9'd1;
          size_d     = '0;
          type_d     = '0;
          status_d   = '0;
          length_d   = '0;
          crc_d      = '0;
          tail_d     = {8'h00, item_i.rx_byte};
          data_d     = '0;
          mism_d     = 1'b0;
        end
      end else begin
        res_o.reply_type    = type_n;
        res_o.type_mismatch = mism_n;
        res_o.data_word     = data_n;
        res_o.data_length   = length_n;
        res_o.frame_bytes   = count_n;
        res_o.outcome       = judge(tail_n, crc_n, status_n);
        if (size_n != 9'd0 && count_n == size_n) begin
          // Last byte: report and return to hunting.
          res_valid_o = 1'b1;
          in_frame_d  = 1'b0;
          count_d     = '0;
          size_d      = '0;
          type_d      = '0;
          status_d    = '0;
          length_d    = '0;
          crc_d       = '0;
          tail_d      = '0;
          data_d      = '0;
          mism_d      = 1'b0;
          idle_d      = '0;
        end else begin
          count_d  = count_n;
          size_d   = size_n;
          type_d   = type_n;
          status_d = status_n;
          length_d = length_n;
          crc_d    = crc_n;
          tail_d   = tail_n;
          data_d   = data_n;
          mism_d   = mism_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      size_q     <= '0;
      type_q     <= '0;
      status_q   <= '0;
      length_q   <= '0;
      crc_q      <= '0;
      tail_q     <= '0;
      data_q     <= '0;
      idle_q     <= '0;
      mism_q     <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      size_q     <= size_d;
      type_q     <= type_d;
      status_q   <= status_d;
      length_q   <= length_d;
      crc_q      <= crc_d;
      tail_q     <= tail_d;
      data_q     <= data_d;
      idle_q     <= idle_d;
      mism_q     <= mism_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/rfp_out_stage.sv =====
// Result register holding one finished item until the sink takes it.
`default_nettype none

module rfp_out_stage
  import rfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire rfp_result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rfp_result_t      res_o
);

  logic        valid_q;
  logic        valid_d;
  rfp_result_t res_q;

  // Free when empty or when the held item leaves this cycle.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== design/reply_frame_parser_crc16.sv =====
// Top level of the CRC-checked serial reply frame parser.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         s_axis_tvalid/tready      tdata: rx_byte, expected_type; tuser: has_byte
//   m_axis    out        m_axis_tvalid/tready      tdata: outcome .. frame_bytes (48 bits)
//   cfg       in         cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// Each item is held in the input register, then the frame logic and the byte-wide
// CRC update run combinationally into the result register.
// One item is accepted per cycle while the result register is free or being read.
// A stalled sink holds the result register; the input register still takes one item.
// Reset loads the register defaults and clears all frame state; no clearing pass.
`default_nettype none

module reply_frame_parser_crc16
  import rfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // rx_byte, expected_type
  input  wire logic        s_axis_tuser,   // has_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // outcome, reply_type, type_mismatch, data_word, data_length, frame_bytes, zero pad
  output logic [47:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i
);

  rfp_item_t   in_item;
  rfp_item_t   item;
  logic        item_valid;
  logic        out_free;
  logic        step;
  logic        res_valid;
  rfp_result_t res;
  rfp_result_t res_q;

  assign in_item.has_byte      = s_axis_tuser;
  assign in_item.rx_byte       = s_axis_tdata[7:0];
  assign in_item.expected_type = s_axis_tdata[15:8];

  // An item moves through the frame logic whenever the result register can take it.
  assign step = item_valid && out_free;

  rfp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .take_i       (step),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  rfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rfp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res_q)
  );

  // Pack the result fields, first field lowest.
  assign m_axis_tdata = {3'b000, res_q.frame_bytes, res_q.data_length, res_q.data_word,
                         res_q.type_mismatch, res_q.reply_type, res_q.outcome};

  // A frame verdict needs at least a complete short frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.outcome != OUT_TIMEOUT |-> res_q.frame_bytes >= ShortFrameSize)
    else $error("frame result with fewer bytes than a short frame");

  // A length byte is only ever taken from a get reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.data_length != 8'h00 |-> res_q.reply_type == ChGet)
    else $error("data length reported for a reply that is not a get");

  // A type mismatch needs the type byte to have arrived.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.type_mismatch |-> res_q.frame_bytes >= 9'd2)
    else $error("type mismatch flagged before the type byte");

  // A result is only loaded when the result register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> out_free)
    else $error("item processed while the result register was blocked");

endmodule

`default_nettype wire

// ===== tb/reply_frame_parser_crc16_tb.sv =====
// Self-checking testbench for the CRC-16 checked reply frame parser.
`default_nettype none

module reply_frame_parser_crc16_tb;
  import rfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // How a stimulus row turns into an item: a literal byte, an idle tick, or a
  // checksum byte worked out from the parser state at the moment it is sent.
  typedef enum logic [2:0] {
    ROW_BYTE,
    ROW_IDLE,
    ROW_CRC_LO,
    ROW_CRC_HI,
    ROW_CRC_BAD
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  val;
    logic [7:0]  exp_type;
    logic        lit_on;
    rfp_result_t lit;
  } row_t;

  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 6;
  localparam int PhaseItems  = 100;

  // Directed rows; a literal result is given only where it is obvious.
  localparam row_t DirectedRows [26] = '{
    '{ROW_IDLE,   8'h00, 8'hFF, 1'b0, '0},
    '{ROW_IDLE,   8'hFF, 8'h00, 1'b0, '0},
    '{ROW_IDLE,   8'h5A, 8'hA5, 1'b1, '{OUT_TIMEOUT, 8'h00, 1'b0, 16'h0000, 8'h00, 9'd0}},
    '{ROW_BYTE,   8'hFF, 8'h00, 1'b0, '0},
    '{ROW_BYTE,   8'h52, 8'h00, 1'b0, '0},
    '{ROW_BYTE,   8'h41, 8'h41, 1'b0, '0},
    '{ROW_BYTE,   8'h06, 8'h00, 1'b0, '0},
    '{ROW_CRC_LO, 8'h00, 8'h00, 1'b0, '0},
    '{ROW_CRC_HI, 8'h00, 8'h00, 1'b1, '{OUT_OK, 8'h41, 1'b0, 16'h0000, 8'h00, 9'd5}},
    '{ROW_BYTE,   8'h52, 8'h00, 1'b0, '0},
    '{ROW_BYTE,   8'h51, 8'h47, 1'b0, '0},
    '{ROW_BYTE,   8'h84, 8'h00, 1'b0, '0},
    '{ROW_CRC_LO, 8'h00, 8'h00, 1'b0, '0},
    '{ROW_CRC_HI, 8'h00, 8'h00, 1'b1, '{OUT_PERM_ERR, 8'h51, 1'b1, 16'h0000, 8'h00, 9'd5}},
    '{ROW_BYTE,   8'h52, 8'h00, 1'b0, '0},
    '{ROW_BYTE,   8'h47, 8'h47, 1'b0, '0},
    '{ROW_BYTE,   8'h06, 8'h00, 1'b0, '0},
    '{ROW_BYTE,   8'h00, 8'h00, 1'b0, '0},
    '{ROW_BYTE,   8'h00, 8'h00, 1'b0, '0},
    '{ROW_CRC_LO, 8'h00, 8'h00, 1'b0, '0},
    '{ROW_CRC_HI, 8'h00, 8'h00, 1'b0, '0},
    '{ROW_BYTE,   8'h52, 8'h00, 1'b0, '0},
    '{ROW_BYTE,   8'h42, 8'h42, 1'b0, '0},
    '{ROW_BYTE,   8'h99, 8'h00, 1'b0, '0},
    '{ROW_CRC_BAD, 8'h00, 8'h00, 1'b0, '0},
    '{ROW_CRC_HI, 8'h00, 8'h00, 1'b1, '{OUT_CRC_BAD, 8'h42, 1'b0, 16'h0000, 8'h00, 9'd5}}
  };

  // Block ports.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [0:0]  cfg_addr_i    = CFG_CRC_POLY;
  logic [15:0] cfg_wdata_i   = '0;

  // Idling percentages, changed between phases.
  int send_gap_pct   = 7;
  int recv_stall_pct = 82;

  int mismatches   = 0;
  int quiet_cycles = 0;

  // Results still to come from the block, oldest first.
  rfp_result_t reports_due [$];

  // Parser state as the testbench expects it.
  logic [15:0] p_poly       = PolyReset;
  logic [15:0] p_idle_limit = IdleReset;
  logic        p_in_frame   = 1'b0;
  logic [8:0]  p_count      = '0;
  logic [8:0]  p_size       = '0;
  logic [7:0]  p_type       = '0;
  logic [7:0]  p_status     = '0;
  logic [7:0]  p_length     = '0;
  logic [15:0] p_crc        = '0;
  logic [15:0] p_tail       = '0;
  logic [15:0] p_word       = '0;
  logic [15:0] p_idle       = '0;
  logic        p_mismatch   = 1'b0;
  // Checksum over the whole frame body, latched when its low byte is sent.
  logic [15:0] body_crc     = '0;

  reply_frame_parser_crc16 i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // One byte through the MSB-first CRC-16 with the current polynomial.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ p_poly) : (c << 1);
    end
    return c;
  endfunction

  // A uniformly random byte.
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic rfp_result_t frame_report(outcome_e oc);
    return '{oc, p_type, p_mismatch, p_word, p_length, p_count};
  endfunction

  function automatic row_t make_row(row_kind_e k, logic [7:0] v, logic [7:0] e);
    row_t r;
    r = '0;
    r.kind = k;
    r.val = v;
    r.exp_type = e;
    return r;
  endfunction

  task automatic clear_frame();
    p_in_frame = 1'b0;
    p_count    = '0;
    p_size     = '0;
    p_type     = '0;
    p_status   = '0;
    p_length   = '0;
    p_crc      = '0;
    p_tail     = '0;
    p_word     = '0;
    p_mismatch = 1'b0;
  endtask

  // Advances the expected parser state by one item; fired says a result is due.
  task automatic parse_item(input rfp_item_t it, output bit fired, output rfp_result_t rep);
    outcome_e oc;
    fired = 1'b0;
    rep = '0;
    if (!it.has_byte) begin
      // Idle tick: count it, or time out once the limit has been reached.
      if (p_idle >= p_idle_limit) begin
        rep = frame_report(OUT_TIMEOUT);
        fired = 1'b1;
        clear_frame();
        p_idle = '0;
      end else begin
        p_idle++;
      end
    end else if (!p_in_frame) begin
      // Hunting: only the reply character opens a frame.
      if (it.rx_byte == ChReply) begin
        clear_frame();
        p_in_frame = 1'b1;
        p_count = 9'd1;
        p_tail = {8'h00, it.rx_byte};
      end
    end else begin
      // Inside a frame: the checksum trails the newest byte by two.
      p_count++;
      if (p_count >= 9'd3) begin
        p_crc = crc16_step(p_crc, p_tail[15:8]);
      end
      p_tail = {p_tail[7:0], it.rx_byte};
      if (p_count == 9'd2) begin
        p_type = it.rx_byte;
        p_mismatch = (it.rx_byte != it.expected_type);
        p_size = (it.rx_byte == ChGet) ? 9'd0 : ShortFrameSize;
      end else if (p_count == 9'd3) begin
        p_status = it.rx_byte;
      end else if (p_count == 9'd4 && p_type == ChGet) begin
        if (p_status == StAck) begin
          p_length = it.rx_byte;
          p_size = GetFrameBase + {1'b0, it.rx_byte};
        end else begin
          p_size = ShortFrameSize;
        end
      end else if (p_count == 9'd6) begin
        p_word[7:0] = it.rx_byte;
      end else if (p_count == 9'd7) begin
        p_word[15:8] = it.rx_byte;
      end
      // Frame complete: the checksum is judged before the status.
      if (p_size != '0 && p_count == p_size) begin
        if (p_tail[15:8] != p_crc[7:0] || p_tail[7:0] != p_crc[15:8]) begin
          oc = OUT_CRC_BAD;
        end else begin
          case (p_status)
            StAck:   oc = OUT_OK;
            StData:  oc = OUT_DATA_ERR;
            StCount: oc = OUT_COUNT_ERR;
            StCmd:   oc = OUT_CMD_ERR;
            StPerm:  oc = OUT_PERM_ERR;
            default: oc = OUT_OTHER_NAK;
          endcase
        end
        rep = frame_report(oc);
        fired = 1'b1;
        clear_frame();
        p_idle = '0;
      end
    end
  endtask

  // Sends one row as an item, after a random gap, and records its result.
  task automatic send_row(input row_t r);
    rfp_item_t   it;
    bit          fired;
    rfp_result_t rep;
    logic [15:0] crc_now;
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    it.has_byte = (r.kind != ROW_IDLE);
    it.expected_type = r.exp_type;
    crc_now = crc16_step(crc16_step(p_crc, p_tail[15:8]), p_tail[7:0]);
    case (r.kind)
      ROW_CRC_LO: begin
        body_crc = crc_now;
        it.rx_byte = crc_now[7:0];
      end
      ROW_CRC_BAD: begin
        body_crc = crc_now;
        it.rx_byte = ~crc_now[7:0];
      end
      ROW_CRC_HI: it.rx_byte = body_crc[15:8];
      default:    it.rx_byte = r.val;
    endcase
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.expected_type, it.rx_byte};
    s_axis_tuser  <= it.has_byte;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    parse_item(it, fired, rep);
    if (r.lit_on) begin
      reports_due.insert(reports_due.size(), r.lit);
    end else if (fired) begin
      reports_due.insert(reports_due.size(), rep);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_CRC_POLY) begin
      p_poly = val;
    end else begin
      p_idle_limit = val;
    end
  endtask

  // Stops sending and waits until every due result has arrived.
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (reports_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One random phase: mostly well-formed frames with random content, the rest
  // noise, idle runs, truncated frames and idle ticks inside frames.
  task automatic run_phase(input logic [15:0] poly, input logic [15:0] limit,
                           input int send_pct, input int recv_pct, input bit go_long);
    row_t       plan [$];
    int         sent;
    int         pick;
    int         sel;
    int         len;
    int         keep;
    logic [7:0] v;
    logic [7:0] t;
    logic [7:0] st;
    logic [7:0] et;
    drain_reports();
    write_reg(CFG_CRC_POLY, poly);
    write_reg(CFG_IDLE_LIMIT, limit);
    send_gap_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < PhaseItems) begin
      plan.delete();
      pick = go_long ? 99 : $urandom_range(99);
      if (pick < 6) begin
        repeat ($urandom_range(1, 4)) begin
          plan.insert(plan.size(), make_row($urandom_range(1) ? ROW_BYTE : ROW_IDLE,
                                            rand_byte(), rand_byte()));
        end
      end else if (pick < 12) begin
        repeat ($urandom_range(1, 8)) begin
          plan.insert(plan.size(), make_row(ROW_IDLE, rand_byte(), rand_byte()));
        end
      end else begin
        // Leading line noise that cannot open a frame.
        repeat ($urandom_range(0, 2)) begin
          v = rand_byte();
          if (v == ChReply) v = 8'h00;
          plan.insert(plan.size(), make_row(ROW_BYTE, v, rand_byte()));
        end
        sel = $urandom_range(9);
        t = (sel < 5) ? ChGet : (sel == 5) ? ChReply : 8'($urandom_range(255));
        sel = $urandom_range(19);
        st = (sel < 11) ? StAck : (sel < 18) ? StData + 8'($urandom_range(3))
                                              : 8'($urandom_range(255));
        et = ($urandom_range(4) != 0) ? t : 8'($urandom_range(255));
        if (go_long) begin
          t = ChGet;
          st = StAck;
        end
        plan.insert(plan.size(), make_row(ROW_BYTE, ChReply, rand_byte()));
        plan.insert(plan.size(), make_row(ROW_BYTE, t, et));
        plan.insert(plan.size(), make_row(ROW_BYTE, st, rand_byte()));
        if (t == ChGet && st == StAck) begin
          sel = $urandom_range(99);
          len = go_long ? 255 : (sel < 88) ? $urandom_range(0, 6)
                                : (sel < 98) ? $urandom_range(7, 40) : $urandom_range(200, 255);
          plan.insert(plan.size(), make_row(ROW_BYTE, 8'(len), rand_byte()));
          repeat (len + 1) begin
            plan.insert(plan.size(), make_row(ROW_BYTE, rand_byte(), rand_byte()));
          end
        end
        // Checksum: mostly right, sometimes the low or the high byte wrong.
        sel = $urandom_range(15);
        plan.insert(plan.size(), make_row((sel == 0) ? ROW_CRC_BAD : ROW_CRC_LO, 8'h00,
                                          rand_byte()));
        plan.insert(plan.size(), make_row((sel == 1) ? ROW_BYTE : ROW_CRC_HI, rand_byte(),
                                          rand_byte()));
        if (!go_long && $urandom_range(9) == 0) begin
          keep = $urandom_range(1, plan.size() - 1);
          while (plan.size() > keep) void'(plan.pop_back());
        end
        if (!go_long && $urandom_range(9) == 0) begin
          plan.insert($urandom_range(1, plan.size() - 1),
                      make_row(ROW_IDLE, rand_byte(), rand_byte()));
        end
      end
      foreach (plan[i]) send_row(plan[i]);
      sent += plan.size();
      go_long = 1'b0;
    end
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin
    rfp_result_t got;
    rfp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.outcome       = outcome_e'(m_axis_tdata[2:0]);
      got.reply_type    = m_axis_tdata[10:3];
      got.type_mismatch = m_axis_tdata[11];
      got.data_word     = m_axis_tdata[27:12];
      got.data_length   = m_axis_tdata[35:28];
      got.frame_bytes   = m_axis_tdata[44:36];
      if (reports_due.size() == 0) begin
        mismatches++;
        $display("%0t: no result due, got %p", $time, got);
      end else begin
        want = reports_due.pop_front();
        if (got.outcome !== want.outcome || got.reply_type !== want.reply_type ||
            got.type_mismatch !== want.type_mismatch || got.data_word !== want.data_word ||
            got.data_length !== want.data_length || got.frame_bytes !== want.frame_bytes) begin
          mismatches++;
          $display("%0t: expected %p, got %p", $time, want, got);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any item moving.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // A short idle limit lets the directed part reach a timeout quickly.
    write_reg(CFG_IDLE_LIMIT, 16'd2);
    foreach (DirectedRows[i]) send_row(DirectedRows[i]);
    run_phase(16'h8005, 16'd3, 7, 82, 1'b0);
    run_phase(16'hFFFF, 16'd0, 7, 82, 1'b0);
    run_phase(16'h0000, 16'hFFFF, 82, 7, 1'b0);
    run_phase(16'($urandom_range(65535)), 16'($urandom_range(6)), 82, 7, 1'b0);
    run_phase(PolyReset, 16'd1, 0, 0, 1'b1);
    run_phase(16'($urandom_range(65535)), IdleReset, 0, 0, 1'b0);
    drain_reports();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
